@@ rtl/lrt_pkg.sv @@
// Shared types and constants for the liveness response table.
`timescale 1ns / 1ps

package lrt_pkg;

    localparam int LOC_W       = 6;
    localparam int OP_W        = 3;
    localparam int REQ_W       = 2;
    localparam int CNT_W       = 32;
    localparam int MAX_RESULTS = 64;
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    typedef enum logic [OP_W-1:0] {
        OP_UPDATE    = 3'd0,
        OP_SWEEP     = 3'd1,
        OP_RESET_ONE = 3'd2,
        OP_REMOVE    = 3'd3,
        OP_RESET_ALL = 3'd4,
        OP_CLEAR_ALL = 3'd5
    } op_t;

    // Reply codes on the request_kind field
    localparam logic [REQ_W-1:0] REQ_ACK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CAND = 2'd1;

    typedef enum logic [1:0] {
        KIND_UNKNOWN = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_CAND    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        RES_DONE  = 2'd0,
        RES_FAULT = 2'd1,
        RES_NONE  = 2'd2
    } res_kind_t;

    typedef struct packed {
        op_t              op;
        logic [LOC_W-1:0] loc;
        logic             in_range;
        kind_t            kind;
        logic [CNT_W-1:0] cnt;
    } cmd_t;

    typedef struct packed {
        logic [LOC_W-1:0] loc;
        res_kind_t        kind;
        logic             is_new;
        logic             not_found;
        logic             last;
    } res_t;

endpackage

@@ rtl/lrt_ifs.sv @@
// Request and result channel interfaces of the liveness response table.
`timescale 1ns / 1ps

interface lrt_in_if import lrt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [LOC_W-1:0] location_index;
    logic [REQ_W-1:0] request_kind;
    logic [CNT_W-1:0] round_counter;

    modport source (
        output valid, operation, location_index, request_kind, round_counter,
        input  ready
    );
    modport sink (
        input  valid, operation, location_index, request_kind, round_counter,
        output ready
    );
endinterface

interface lrt_out_if import lrt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LOC_W-1:0] location_index_out;
    logic [1:0]       result_kind;
    logic             is_new;
    logic             not_found;
    logic             last;

    modport source (
        output valid, location_index_out, result_kind, is_new, not_found, last,
        input  ready
    );
    modport sink (
        input  valid, location_index_out, result_kind, is_new, not_found, last,
        output ready
    );
endinterface

@@ rtl/lrt_front.sv @@
// Front end: accepts request beats, decodes them and queues commands.
`timescale 1ns / 1ps

module lrt_front import lrt_pkg::*; #(
    parameter int NUM_LOCATIONS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    lrt_in_if.sink      in_ch,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  logic        cmd_pop
);

    localparam int QDEPTH = 2;

    cmd_t       q_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    logic op_ok;
    logic accept;
    logic push;
    cmd_t new_cmd;

    always_comb
    begin
        unique case (in_ch.operation) inside
            OP_UPDATE, OP_SWEEP, OP_RESET_ONE, OP_REMOVE, OP_RESET_ALL, OP_CLEAR_ALL:
                op_ok = 1'b1;
            default:
                op_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        new_cmd.op       = op_t'(in_ch.operation);
        new_cmd.loc      = in_ch.location_index;
        new_cmd.in_range = (32'(in_ch.location_index) < 32'(NUM_LOCATIONS));
        new_cmd.cnt      = in_ch.round_counter;
        unique case (in_ch.request_kind)
            REQ_ACK:  new_cmd.kind = KIND_ACK;
            REQ_CAND: new_cmd.kind = KIND_CAND;
            default:  new_cmd.kind = KIND_UNKNOWN;
        endcase
    end

    assign in_ch.ready = (count_reg != 2'(QDEPTH));
    assign accept      = in_ch.valid && in_ch.ready;
    // drop unused operation codes at the door
    assign push        = accept && op_ok;

    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push    ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(cmd_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/lrt_back.sv @@
// Back end: executes table commands against the entry memory and emits results.
`timescale 1ns / 1ps

module lrt_back import lrt_pkg::*; #(
    parameter int NUM_LOCATIONS = 64,
    parameter int COUNTER_BITS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    lrt_out_if.source   out_ch
);

    localparam int IDX_W = $clog2(NUM_LOCATIONS);
    localparam int CTR_W = IDX_W + 1;

    typedef enum logic [3:0] {
        ST_IDLE      = 4'b0001,
        ST_SWEEP     = 4'b0010,
        ST_SWEEP_END = 4'b0100,
        ST_WIPE      = 4'b1000
    } state_t;

    // Entry memory
    logic [1:0]              kind_mem [NUM_LOCATIONS];
    logic [COUNTER_BITS-1:0] cnt_mem  [NUM_LOCATIONS];
    logic [1:0]              kind_q;
    logic [COUNTER_BITS-1:0] cnt_q;

    logic                    kind_we, cnt_we, rd_en;
    logic [IDX_W-1:0]        wr_addr, rd_addr;
    logic [1:0]              wr_kind;
    logic [COUNTER_BITS-1:0] wr_cnt;

    state_t                   state_reg, state_next;
    logic [NUM_LOCATIONS-1:0] valid_reg, valid_next;
    logic [CTR_W-1:0]         rd_idx_reg, rd_idx_next;
    logic                     ex_valid_reg, ex_valid_next;
    logic [IDX_W-1:0]         ex_idx_reg, ex_idx_next;
    logic [COUNTER_BITS-1:0]  round_reg, round_next;
    logic [NRES_W-1:0]        nres_reg, nres_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]         pend_idx_reg, pend_idx_next;
    logic                     out_valid_reg, out_valid_next;
    res_t                     out_res_reg;

    logic             out_free;
    logic             res_push;
    res_t             res;
    logic [IDX_W-1:0] cmd_idx;
    logic             hit;
    logic             ex_live, ex_unknown, fault, stale, stall;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign cmd_idx  = IDX_W'(cmd.loc);
    assign hit      = cmd.in_range && valid_reg[cmd_idx];

    assign ex_live    = ex_valid_reg && valid_reg[ex_idx_reg];
    assign ex_unknown = (kind_q == KIND_UNKNOWN);
    assign fault      = ex_live && ex_unknown && (nres_reg < NRES_W'(MAX_RESULTS));
    assign stale      = ex_live && !ex_unknown && (cnt_q != round_reg);
    // a new fault pushes the held one out, so it waits for a free output slot
    assign stall      = fault && pend_valid_reg && !out_free;

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        rd_idx_next     = rd_idx_reg;
        ex_valid_next   = ex_valid_reg;
        ex_idx_next     = ex_idx_reg;
        round_next      = round_reg;
        nres_next       = nres_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        cmd_pop         = 1'b0;
        res_push        = 1'b0;
        res             = '0;
        kind_we         = 1'b0;
        cnt_we          = 1'b0;
        wr_addr         = cmd_idx;
        wr_kind         = KIND_UNKNOWN;
        wr_cnt          = '0;
        rd_en           = 1'b0;
        rd_addr         = rd_idx_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        OP_SWEEP:
                        begin
                            cmd_pop         = 1'b1;
                            rd_idx_next     = '0;
                            ex_valid_next   = 1'b0;
                            nres_next       = '0;
                            pend_valid_next = 1'b0;
                            round_next      = cmd.cnt[COUNTER_BITS-1:0];
                            state_next      = ST_SWEEP;
                        end
                        OP_RESET_ALL:
                        begin
                            cmd_pop     = 1'b1;
                            rd_idx_next = '0;
                            state_next  = ST_WIPE;
                        end
                        default:
                        begin
                            if (out_free)
                            begin
                                cmd_pop  = 1'b1;
                                res_push = 1'b1;
                                res.loc  = cmd.loc;
                                res.kind = RES_DONE;
                                res.last = 1'b1;
                                case (cmd.op)
                                    OP_UPDATE:
                                    begin
                                        if (cmd.in_range)
                                        begin
                                            res.is_new          = !valid_reg[cmd_idx];
                                            valid_next[cmd_idx] = 1'b1;
                                            kind_we             = 1'b1;
                                            cnt_we              = 1'b1;
                                            wr_kind             = cmd.kind;
                                            wr_cnt              = cmd.cnt[COUNTER_BITS-1:0];
                                        end
                                    end
                                    OP_RESET_ONE:
                                    begin
                                        res.not_found = !hit;
                                        kind_we       = hit;
                                        cnt_we        = hit;
                                    end
                                    OP_REMOVE:
                                    begin
                                        if (cmd.in_range)
                                        begin
                                            valid_next[cmd_idx] = 1'b0;
                                        end
                                    end
                                    OP_CLEAR_ALL:
                                    begin
                                        valid_next = '0;
                                        res.loc    = '0;
                                    end
                                    default:
                                    begin
                                        res.loc = cmd.loc;
                                    end
                                endcase
                            end
                        end
                    endcase
                end
            end

            ST_WIPE:
            begin
                // write every entry to unknown; invalid entries are rewritten on update
                kind_we = 1'b1;
                cnt_we  = 1'b1;
                wr_addr = rd_idx_reg[IDX_W-1:0];
                if (rd_idx_reg == CTR_W'(NUM_LOCATIONS - 1))
                begin
                    if (out_free)
                    begin
                        res_push   = 1'b1;
                        res.kind   = RES_DONE;
                        res.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + CTR_W'(1);
                end
            end

            ST_SWEEP:
            begin
                if (!stall)
                begin
                    if (fault)
                    begin
                        valid_next[ex_idx_reg] = 1'b0;
                        nres_next              = nres_reg + NRES_W'(1);
                        if (pend_valid_reg)
                        begin
                            res_push = 1'b1;
                            res.loc  = LOC_W'(pend_idx_reg);
                            res.kind = RES_FAULT;
                        end
                        pend_idx_next   = ex_idx_reg;
                        pend_valid_next = 1'b1;
                    end
                    if (stale)
                    begin
                        kind_we = 1'b1;
                        wr_addr = ex_idx_reg;
                    end
                    if (rd_idx_reg != CTR_W'(NUM_LOCATIONS))
                    begin
                        rd_en         = 1'b1;
                        ex_valid_next = 1'b1;
                        ex_idx_next   = rd_idx_reg[IDX_W-1:0];
                        rd_idx_next   = rd_idx_reg + CTR_W'(1);
                    end
                    else
                    begin
                        ex_valid_next = 1'b0;
                        state_next    = ST_SWEEP_END;
                    end
                end
            end

            ST_SWEEP_END:
            begin
                if (out_free)
                begin
                    res_push = 1'b1;
                    res.last = 1'b1;
                    if (pend_valid_reg)
                    begin
                        res.loc  = LOC_W'(pend_idx_reg);
                        res.kind = RES_FAULT;
                    end
                    else
                    begin
                        res.kind = RES_NONE;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (res_push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (kind_we)
        begin
            kind_mem[wr_addr] <= wr_kind;
        end
        if (cnt_we)
        begin
            cnt_mem[wr_addr] <= wr_cnt;
        end
        if (rd_en)
        begin
            kind_q <= kind_mem[rd_addr];
            cnt_q  <= cnt_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            out_res_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            rd_idx_reg     <= '0;
            ex_valid_reg   <= 1'b0;
            ex_idx_reg     <= '0;
            round_reg      <= '0;
            nres_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            rd_idx_reg     <= rd_idx_next;
            ex_valid_reg   <= ex_valid_next;
            ex_idx_reg     <= ex_idx_next;
            round_reg      <= round_next;
            nres_reg       <= nres_next;
            pend_valid_reg <= pend_valid_next;
            pend_idx_reg   <= pend_idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.location_index_out = out_res_reg.loc;
    assign out_ch.result_kind        = out_res_reg.kind;
    assign out_ch.is_new             = out_res_reg.is_new;
    assign out_ch.not_found          = out_res_reg.not_found;
    assign out_ch.last               = out_res_reg.last;

`ifndef NO_ASSERTIONS
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("back state not one-hot");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("held fault left over after sweep");

    a_pending_counted: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (nres_reg != '0))
        else $error("held fault without a fault count");

    a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nres_reg <= NRES_W'(MAX_RESULTS))
        else $error("sweep reported too many faults");

    a_ex_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ex_valid_reg |-> (CTR_W'(ex_idx_reg) < CTR_W'(NUM_LOCATIONS)))
        else $error("sweep examines an entry beyond the table");
`endif

endmodule

@@ rtl/liveness_response_table.sv @@
// Top level of the liveness response table.
//
// Usage: requests arrive on in_ch (valid/ready); each accepted beat carries an
// operation, a location index, a reply kind and a round counter. Results
// leave on out_ch (valid/ready); every request with a defined operation code
// gives one or more result beats, the final one flagged by last. Unused
// operation codes are accepted and dropped.
// A request is queued at the accepting edge; when the back end is idle and
// the output register is free, it executes a single-entry operation or
// clear-all and registers the result beat in the output register. Reset-all
// walks the entry memory one entry a cycle, then registers its result beat.
// Sweep reads one entry a cycle through the single memory read port, except
// while a held fault waits for a free output slot; its final beat follows
// the last entry, later when the receiver stalls. The front queue holds two
// requests, so new beats are taken while the back end works.
// Reset clears every valid mark, the queue and the output register; kind and
// counter memories are not cleared and their contents are only used for
// valid entries. A stalled receiver holds the output beat; the back end waits
// when it must emit and the output register is still full.
`timescale 1ns / 1ps

module liveness_response_table import lrt_pkg::*; #(
    parameter int NUM_LOCATIONS = 64,
    parameter int COUNTER_BITS  = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    lrt_in_if.sink    in_ch,
    lrt_out_if.source out_ch
);

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    lrt_front #(
        .NUM_LOCATIONS (NUM_LOCATIONS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    lrt_back #(
        .NUM_LOCATIONS (NUM_LOCATIONS),
        .COUNTER_BITS  (COUNTER_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .out_ch    (out_ch)
    );

endmodule
